@@ src/frsnl_pkg.sv @@
// Package for the Fresnel dielectric reflectance pipeline.
// Holds the fixed-point constants, step counts and register index codes.
// It has no dependencies.
package frsnl_pkg;

   localparam int unsigned ONE_Q14 = 16384;
   localparam int unsigned ONE_Q16 = 65536;

   // Restoring division of the transmitted sine squared: 28 quotient bits.
   localparam int unsigned QDIV_STEPS = 28;
   // Square root of a value of at most 2^28: 15 result bits.
   localparam int unsigned SQRT_STEPS = 15;
   // Rounded amplitude ratio: 17 quotient bits, at most 2^16.
   localparam int unsigned RDIV_STEPS = 17;

   localparam logic [1:0] CSR_INDEX_INCIDENT    = 2'd0;
   localparam logic [1:0] CSR_INDEX_TRANSMITTED = 2'd1;

   localparam logic [13:0] INDEX_INCIDENT_RESET    = 14'd4096;
   localparam logic [13:0] INDEX_TRANSMITTED_RESET = 14'd6144;

endpackage

@@ src/fresnel_dielectric_reflectance.sv @@
// Fresnel dielectric reflectance: a fully pipelined fixed-point datapath.
// Depends on frsnl_pkg for constants and register index codes.
// Throughput: one transfer per cycle; the pipeline is set by the 28-step
// division, the 15-step square root and the 17-step ratio division.
// A response stall freezes every stage; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and loads the
// index registers with 4096 and 6144 (1.0 and 1.5 in Q2.12).
module fresnel_dielectric_reflectance
   import frsnl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_cos_incident,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_reflectance,
   output logic               rsp_total_internal,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_wdata
);

   // The whole pipeline moves together; it holds only while the
   // finished response waits for the consumer.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Configuration registers.
   logic [13:0] idx_inc_ff, idx_trn_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_inc_ff <= INDEX_INCIDENT_RESET;
         idx_trn_ff <= INDEX_TRANSMITTED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INDEX_INCIDENT:    idx_inc_ff <= csr_wdata;
            CSR_INDEX_TRANSMITTED: idx_trn_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage A: clamp the cosine, take its magnitude and swap the indices
   // when the ray leaves the medium (a zero cosine counts as leaving).
   logic        a_vld_ff;
   logic [14:0] a_c_ff, a_c_in;
   logic [13:0] a_ni_ff, a_nt_ff, a_ni_in, a_nt_in;
   logic signed [15:0] cs_clamp;
   always_comb begin
      if (req_cos_incident > 16'sd16384)       cs_clamp = 16'sd16384;
      else if (req_cos_incident < -16'sd16384) cs_clamp = -16'sd16384;
      else                                     cs_clamp = req_cos_incident;
      a_c_in  = cs_clamp[15] ? 15'(-cs_clamp) : cs_clamp[14:0];
      a_ni_in = (cs_clamp > 16'sd0) ? idx_inc_ff : idx_trn_ff;
      a_nt_in = (cs_clamp > 16'sd0) ? idx_trn_ff : idx_inc_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req_valid;
      if (adv) begin
         a_c_ff  <= a_c_in;
         a_ni_ff <= a_ni_in;
         a_nt_ff <= a_nt_in;
      end
   end

   // Stage B: squares of the cosine and of both indices.
   logic        b_vld_ff;
   logic [28:0] b_cc_ff;
   logic [27:0] b_ni2_ff, b_nt2_ff;
   logic [14:0] b_c_ff;
   logic [13:0] b_ni_ff, b_nt_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
      if (adv) begin
         b_cc_ff  <= 29'(30'(a_c_ff) * 30'(a_c_ff));
         b_ni2_ff <= 28'(a_ni_ff) * 28'(a_ni_ff);
         b_nt2_ff <= 28'(a_nt_ff) * 28'(a_nt_ff);
         b_c_ff   <= a_c_ff;
         b_ni_ff  <= a_ni_ff;
         b_nt_ff  <= a_nt_ff;
      end
   end

   // Stage C: incident sine squared in Q1.28.
   logic        c_vld_ff;
   logic [28:0] c_s2_ff;
   logic [27:0] c_ni2_ff, c_nt2_ff;
   logic [14:0] c_c_ff;
   logic [13:0] c_ni_ff, c_nt_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (adv) c_vld_ff <= b_vld_ff;
      if (adv) begin
         c_s2_ff  <= 29'h1000_0000 - b_cc_ff;
         c_ni2_ff <= b_ni2_ff;
         c_nt2_ff <= b_nt2_ff;
         c_c_ff   <= b_c_ff;
         c_ni_ff  <= b_ni_ff;
         c_nt_ff  <= b_nt_ff;
      end
   end

   // Stage D: ni^2 * s2, which stays below 2^56.
   logic        d_vld_ff;
   logic [55:0] d_lhs_ff;
   logic [27:0] d_nt2_ff;
   logic [14:0] d_c_ff;
   logic [13:0] d_ni_ff, d_nt_ff;
   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else if (adv) d_vld_ff <= c_vld_ff;
      if (adv) begin
         d_lhs_ff <= 56'(57'(c_ni2_ff) * 57'(c_s2_ff));
         d_nt2_ff <= c_nt2_ff;
         d_c_ff   <= c_c_ff;
         d_ni_ff  <= c_ni_ff;
         d_nt_ff  <= c_nt_ff;
      end
   end

   // Division lane: q = lhs / nt^2, one quotient bit per stage. When no
   // total internal reflection occurs the quotient is below 2^28. The
   // total internal reflection test is made in the first step.
   logic        qv_vld_ff [QDIV_STEPS];
   logic        qv_tir_ff [QDIV_STEPS];
   logic [55:0] qv_rem_ff [QDIV_STEPS];
   logic [27:0] qv_quo_ff [QDIV_STEPS];
   logic [27:0] qv_nt2_ff [QDIV_STEPS];
   logic [14:0] qv_c_ff   [QDIV_STEPS];
   logic [13:0] qv_ni_ff  [QDIV_STEPS];
   logic [13:0] qv_nt_ff  [QDIV_STEPS];

   for (genvar j = 0; j < QDIV_STEPS; j++) begin : g_qdiv
      localparam int unsigned K = QDIV_STEPS - 1 - j;
      logic        vld_src, tir_src;
      logic [55:0] rem_src, sub, rem_in;
      logic [27:0] quo_src, quo_in, nt2_src;
      logic [14:0] c_src;
      logic [13:0] ni_src, nt_src;
      if (j == 0) begin : g_first
         assign vld_src = d_vld_ff;
         assign tir_src = d_lhs_ff >= {d_nt2_ff, 28'd0};
         assign rem_src = d_lhs_ff;
         assign quo_src = '0;
         assign nt2_src = d_nt2_ff;
         assign c_src   = d_c_ff;
         assign ni_src  = d_ni_ff;
         assign nt_src  = d_nt_ff;
      end else begin : g_next
         assign vld_src = qv_vld_ff[j-1];
         assign tir_src = qv_tir_ff[j-1];
         assign rem_src = qv_rem_ff[j-1];
         assign quo_src = qv_quo_ff[j-1];
         assign nt2_src = qv_nt2_ff[j-1];
         assign c_src   = qv_c_ff[j-1];
         assign ni_src  = qv_ni_ff[j-1];
         assign nt_src  = qv_nt_ff[j-1];
      end
      always_comb begin
         sub    = 56'(nt2_src) << K;
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= sub) begin
            rem_in    = rem_src - sub;
            quo_in[K] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) qv_vld_ff[j] <= 1'b0;
         else if (adv) qv_vld_ff[j] <= vld_src;
         if (adv) begin
            qv_tir_ff[j] <= tir_src;
            qv_rem_ff[j] <= rem_in;
            qv_quo_ff[j] <= quo_in;
            qv_nt2_ff[j] <= nt2_src;
            qv_c_ff[j]   <= c_src;
            qv_ni_ff[j]  <= ni_src;
            qv_nt_ff[j]  <= nt_src;
         end
      end
   end

   // Square root lane: ct = floor(sqrt(2^28 - q)), one result bit per stage.
   logic        sq_vld_ff [SQRT_STEPS];
   logic        sq_tir_ff [SQRT_STEPS];
   logic [28:0] sq_rem_ff [SQRT_STEPS];
   logic [28:0] sq_res_ff [SQRT_STEPS];
   logic [14:0] sq_c_ff   [SQRT_STEPS];
   logic [13:0] sq_ni_ff  [SQRT_STEPS];
   logic [13:0] sq_nt_ff  [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int unsigned SH = 2 * (SQRT_STEPS - 1 - j);
      logic        vld_src, tir_src;
      logic [28:0] rem_src, res_src, rem_in, res_in, bitv;
      logic [29:0] trial;
      logic [14:0] c_src;
      logic [13:0] ni_src, nt_src;
      if (j == 0) begin : g_first
         assign vld_src = qv_vld_ff[QDIV_STEPS-1];
         assign tir_src = qv_tir_ff[QDIV_STEPS-1];
         assign rem_src = 29'h1000_0000 - 29'(qv_quo_ff[QDIV_STEPS-1]);
         assign res_src = '0;
         assign c_src   = qv_c_ff[QDIV_STEPS-1];
         assign ni_src  = qv_ni_ff[QDIV_STEPS-1];
         assign nt_src  = qv_nt_ff[QDIV_STEPS-1];
      end else begin : g_next
         assign vld_src = sq_vld_ff[j-1];
         assign tir_src = sq_tir_ff[j-1];
         assign rem_src = sq_rem_ff[j-1];
         assign res_src = sq_res_ff[j-1];
         assign c_src   = sq_c_ff[j-1];
         assign ni_src  = sq_ni_ff[j-1];
         assign nt_src  = sq_nt_ff[j-1];
      end
      always_comb begin
         bitv  = 29'd1 << SH;
         trial = 30'(res_src) + 30'(bitv);
         if (30'(rem_src) >= trial) begin
            rem_in = rem_src - trial[28:0];
            res_in = (res_src >> 1) + bitv;
         end else begin
            rem_in = rem_src;
            res_in = res_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[j] <= 1'b0;
         else if (adv) sq_vld_ff[j] <= vld_src;
         if (adv) begin
            sq_tir_ff[j] <= tir_src;
            sq_rem_ff[j] <= rem_in;
            sq_res_ff[j] <= res_in;
            sq_c_ff[j]   <= c_src;
            sq_ni_ff[j]  <= ni_src;
            sq_nt_ff[j]  <= nt_src;
         end
      end
   end

   // Stage P: the four products. Lane 0 is parallel, lane 1 perpendicular.
   logic        p_vld_ff, p_tir_ff;
   logic [28:0] p_a_ff [2];
   logic [28:0] p_b_ff [2];
   logic [14:0] ct;
   assign ct = sq_res_ff[SQRT_STEPS-1][14:0];
   always_ff @(posedge clock) begin
      if (reset) p_vld_ff <= 1'b0;
      else if (adv) p_vld_ff <= sq_vld_ff[SQRT_STEPS-1];
      if (adv) begin
         p_tir_ff  <= sq_tir_ff[SQRT_STEPS-1];
         p_a_ff[0] <= 29'(sq_nt_ff[SQRT_STEPS-1]) * 29'(sq_c_ff[SQRT_STEPS-1]);
         p_b_ff[0] <= 29'(sq_ni_ff[SQRT_STEPS-1]) * 29'(ct);
         p_a_ff[1] <= 29'(sq_ni_ff[SQRT_STEPS-1]) * 29'(sq_c_ff[SQRT_STEPS-1]);
         p_b_ff[1] <= 29'(sq_nt_ff[SQRT_STEPS-1]) * 29'(ct);
      end
   end

   // Stage N: sum, absolute difference and the rounded numerator.
   logic        n_vld_ff, n_tir_ff;
   logic [45:0] n_num_ff [2];
   logic [29:0] n_den_ff [2];
   logic        n_dz_ff  [2];
   for (genvar l = 0; l < 2; l++) begin : g_numer
      logic [29:0] den;
      logic [28:0] dif;
      always_comb begin
         den = 30'(p_a_ff[l]) + 30'(p_b_ff[l]);
         dif = (p_a_ff[l] >= p_b_ff[l]) ? p_a_ff[l] - p_b_ff[l] : p_b_ff[l] - p_a_ff[l];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            n_num_ff[l] <= {1'b0, dif, 16'd0} + 46'(den >> 1);
            n_den_ff[l] <= den;
            n_dz_ff[l]  <= (den == '0);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) n_vld_ff <= 1'b0;
      else if (adv) n_vld_ff <= p_vld_ff;
      if (adv) n_tir_ff <= p_tir_ff;
   end

   // Ratio division lanes: r = num / den, at most 2^16, one bit per stage.
   logic        rv_vld_ff [RDIV_STEPS];
   logic        rv_tir_ff [RDIV_STEPS];
   logic [45:0] rv_rem_ff [RDIV_STEPS][2];
   logic [16:0] rv_quo_ff [RDIV_STEPS][2];
   logic [29:0] rv_den_ff [RDIV_STEPS][2];
   logic        rv_dz_ff  [RDIV_STEPS][2];

   for (genvar j = 0; j < RDIV_STEPS; j++) begin : g_rdiv
      localparam int unsigned K = RDIV_STEPS - 1 - j;
      logic vld_src, tir_src;
      if (j == 0) begin : g_first
         assign vld_src = n_vld_ff;
         assign tir_src = n_tir_ff;
      end else begin : g_next
         assign vld_src = rv_vld_ff[j-1];
         assign tir_src = rv_tir_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (reset) rv_vld_ff[j] <= 1'b0;
         else if (adv) rv_vld_ff[j] <= vld_src;
         if (adv) rv_tir_ff[j] <= tir_src;
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [45:0] rem_src, sub, rem_in;
         logic [16:0] quo_src, quo_in;
         logic [29:0] den_src;
         logic        dz_src;
         if (j == 0) begin : g_first
            assign rem_src = n_num_ff[l];
            assign quo_src = '0;
            assign den_src = n_den_ff[l];
            assign dz_src  = n_dz_ff[l];
         end else begin : g_next
            assign rem_src = rv_rem_ff[j-1][l];
            assign quo_src = rv_quo_ff[j-1][l];
            assign den_src = rv_den_ff[j-1][l];
            assign dz_src  = rv_dz_ff[j-1][l];
         end
         always_comb begin
            sub    = 46'(den_src) << K;
            rem_in = rem_src;
            quo_in = quo_src;
            if (rem_src >= sub) begin
               rem_in    = rem_src - sub;
               quo_in[K] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rv_rem_ff[j][l] <= rem_in;
               rv_quo_ff[j][l] <= quo_in;
               rv_den_ff[j][l] <= den_src;
               rv_dz_ff[j][l]  <= dz_src;
            end
         end
      end
   end

   // Stage S: squared ratios, rounded to Q1.16; a zero denominator gives one.
   logic        s_vld_ff, s_tir_ff;
   logic [16:0] s_r2_ff [2];
   for (genvar l = 0; l < 2; l++) begin : g_square
      logic [33:0] sq;
      assign sq = 34'(rv_quo_ff[RDIV_STEPS-1][l]) * 34'(rv_quo_ff[RDIV_STEPS-1][l])
                  + 34'd32768;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_r2_ff[l] <= rv_dz_ff[RDIV_STEPS-1][l] ? 17'(ONE_Q16) : sq[32:16];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s_vld_ff <= 1'b0;
      else if (adv) s_vld_ff <= rv_vld_ff[RDIV_STEPS-1];
      if (adv) s_tir_ff <= rv_tir_ff[RDIV_STEPS-1];
   end

   // Stage O: average of both polarizations, or one under total reflection.
   logic        o_vld_ff, o_tir_ff;
   logic [16:0] o_refl_ff;
   logic [17:0] avg_sum;
   assign avg_sum = 18'(s_r2_ff[0]) + 18'(s_r2_ff[1]) + 18'd1;
   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else if (adv) o_vld_ff <= s_vld_ff;
      if (adv) begin
         o_tir_ff  <= s_tir_ff;
         o_refl_ff <= s_tir_ff ? 17'(ONE_Q16) : avg_sum[17:1];
      end
   end

   assign rsp_valid          = o_vld_ff;
   assign rsp_reflectance    = o_refl_ff;
   assign rsp_total_internal = o_tir_ff;

   // Total internal reflection always reports a reflectance of exactly one.
   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == 17'(ONE_Q16))
      else $error("total internal reflection without unit reflectance");

   // The reflectance never exceeds one.
   a_refl_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= 17'(ONE_Q16))
      else $error("reflectance above one");

   // While the response is held, the first stage does not move.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(a_vld_ff) && $stable(a_c_ff))
      else $error("pipeline advanced during a stall");

   // A configuration transfer to the incident index lands in its register.
   a_csr_inc: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_INDEX_INCIDENT
      |=> idx_inc_ff == $past(csr_wdata))
      else $error("incident index write lost");

endmodule
